// File: sv/rebd_pkg.sv
// ----------------------------------------------------------------------------
// rebd_pkg
// Shared types and constants for the rotary encoder and button decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rebd_pkg;

    localparam int TIMER_WIDTH   = 16;
    localparam int CFG_WIDTH     = 16;
    localparam int CFG_IDX_WIDTH = 1;

    localparam logic [CFG_WIDTH-1:0] DEBOUNCE_RESET   = 16'd20;
    localparam logic [CFG_WIDTH-1:0] LONG_PRESS_RESET = 16'd600;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_DEBOUNCE   = 1'd0,
        REG_LONG_PRESS = 1'd1
    } t_reg_idx;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_QUAD   = 2'd1,
        OP_BUTTON = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_SHORT = 3'd1,
        EV_LONG  = 3'd2,
        EV_RIGHT = 3'd3,
        EV_LEFT  = 3'd4
    } t_event;

    // full-step quadrature states, one-hot
    typedef enum logic [6:0] {
        Q_START = 7'b0000001,
        Q_CWF   = 7'b0000010,
        Q_CWB   = 7'b0000100,
        Q_CWN   = 7'b0001000,
        Q_CCWB  = 7'b0010000,
        Q_CCWF  = 7'b0100000,
        Q_CCWN  = 7'b1000000
    } t_quad;

    typedef struct packed {
        logic cw;
        logic ccw;
    } t_quad_emit;

    typedef struct packed {
        t_op  op;
        logic pin_a;
        logic pin_b;
        logic button_level;
    } t_in_word;

endpackage

`default_nettype wire

// File: sv/rebd_quad.sv
// ----------------------------------------------------------------------------
// rebd_quad
// Full-step quadrature transition table with step-complete outputs.
// ----------------------------------------------------------------------------
`default_nettype none

module rebd_quad (
    input  var rebd_pkg::t_quad      i_state,
    input  wire logic [1:0]          i_pins,    // {B,A}
    output     rebd_pkg::t_quad      o_state,
    output     rebd_pkg::t_quad_emit o_emit
);

    always_comb begin
        o_state    = rebd_pkg::Q_START;
        o_emit.cw  = 1'b0;
        o_emit.ccw = 1'b0;
        case (i_state)
            rebd_pkg::Q_CWF: begin
                case (i_pins)
                    2'b00:   o_state = rebd_pkg::Q_CWN;
                    2'b10:   o_state = rebd_pkg::Q_CWF;
                    2'b11:   o_emit.cw = 1'b1;
                    default: o_state = rebd_pkg::Q_START;
                endcase
            end
            rebd_pkg::Q_CWB: begin
                case (i_pins)
                    2'b00:   o_state = rebd_pkg::Q_CWN;
                    2'b01:   o_state = rebd_pkg::Q_CWB;
                    default: o_state = rebd_pkg::Q_START;
                endcase
            end
            rebd_pkg::Q_CWN: begin
                case (i_pins)
                    2'b00:   o_state = rebd_pkg::Q_CWN;
                    2'b01:   o_state = rebd_pkg::Q_CWB;
                    2'b10:   o_state = rebd_pkg::Q_CWF;
                    default: o_state = rebd_pkg::Q_START;
                endcase
            end
            rebd_pkg::Q_CCWB: begin
                case (i_pins)
                    2'b00:   o_state = rebd_pkg::Q_CCWN;
                    2'b10:   o_state = rebd_pkg::Q_CCWB;
                    default: o_state = rebd_pkg::Q_START;
                endcase
            end
            rebd_pkg::Q_CCWF: begin
                case (i_pins)
                    2'b00:   o_state = rebd_pkg::Q_CCWN;
                    2'b01:   o_state = rebd_pkg::Q_CCWF;
                    2'b11:   o_emit.ccw = 1'b1;
                    default: o_state = rebd_pkg::Q_START;
                endcase
            end
            rebd_pkg::Q_CCWN: begin
                case (i_pins)
                    2'b00:   o_state = rebd_pkg::Q_CCWN;
                    2'b01:   o_state = rebd_pkg::Q_CCWF;
                    2'b10:   o_state = rebd_pkg::Q_CCWB;
                    default: o_state = rebd_pkg::Q_START;
                endcase
            end
            default: begin
                case (i_pins)
                    2'b01:   o_state = rebd_pkg::Q_CWB;
                    2'b10:   o_state = rebd_pkg::Q_CCWB;
                    default: o_state = rebd_pkg::Q_START;
                endcase
            end
        endcase
    end

endmodule

`default_nettype wire

// File: sv/rebd_core.sv
// ----------------------------------------------------------------------------
// rebd_core
// Decoder state: quadrature tracker, sticky flags, button press timing and
// event priority on read. Processes one word per enabled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rebd_core #(
    parameter int TIMER_WIDTH = rebd_pkg::TIMER_WIDTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_en,
    input  var  rebd_pkg::t_in_word                i_word,
    input  wire logic [rebd_pkg::CFG_WIDTH-1:0]    i_debounce,
    input  wire logic [rebd_pkg::CFG_WIDTH-1:0]    i_long_press,
    output      rebd_pkg::t_event                  o_event
);

    localparam int CMP_WIDTH = (TIMER_WIDTH > rebd_pkg::CFG_WIDTH) ?
                               TIMER_WIDTH : rebd_pkg::CFG_WIDTH;

    rebd_pkg::t_quad      r_quad, n_quad, w_quad_next;
    rebd_pkg::t_quad_emit w_emit;
    logic                 r_right, n_right;
    logic                 r_left, n_left;
    logic                 r_short, n_short;
    logic                 r_armed, n_armed;
    logic                 r_was_pressed, n_was_pressed;
    logic [TIMER_WIDTH-1:0] r_elapsed, n_elapsed;

    logic [CMP_WIDTH-1:0] w_el, w_deb, w_lp;

    assign w_el  = CMP_WIDTH'(r_elapsed);
    assign w_deb = CMP_WIDTH'(i_debounce);
    assign w_lp  = CMP_WIDTH'(i_long_press);

    rebd_quad u_quad (
        .i_state (r_quad),
        .i_pins  ({i_word.pin_b, i_word.pin_a}),
        .o_state (w_quad_next),
        .o_emit  (w_emit)
    );

    always_comb begin
        n_quad        = r_quad;
        n_right       = r_right;
        n_left        = r_left;
        n_short       = r_short;
        n_armed       = r_armed;
        n_was_pressed = r_was_pressed;
        n_elapsed     = r_elapsed;
        o_event       = rebd_pkg::EV_NONE;
        case (i_word.op)
            rebd_pkg::OP_TICK: begin
                if (r_elapsed != {TIMER_WIDTH{1'b1}}) begin
                    n_elapsed = r_elapsed + 1'b1;
                end
            end
            rebd_pkg::OP_QUAD: begin
                n_quad = w_quad_next;
                if (w_emit.cw) begin
                    n_right = 1'b1;
                end else if (w_emit.ccw) begin
                    n_left = 1'b1;
                end
                n_elapsed = '0;
            end
            rebd_pkg::OP_BUTTON: begin
                if (w_el >= w_deb) begin
                    if (!r_was_pressed) begin
                        n_armed = 1'b1;
                    end else if (w_el <= w_lp && r_armed) begin
                        n_short = 1'b1;
                        n_armed = 1'b0;
                    end
                    n_was_pressed = ~i_word.button_level;
                    n_elapsed     = '0;
                end
            end
            rebd_pkg::OP_READ: begin
                if (r_short) begin
                    n_short = 1'b0;
                    o_event = rebd_pkg::EV_SHORT;
                end else if (r_armed && w_el >= w_lp) begin
                    n_armed = 1'b0;
                    o_event = rebd_pkg::EV_LONG;
                end else if (r_right) begin
                    n_right = 1'b0;
                    o_event = rebd_pkg::EV_RIGHT;
                end else if (r_left) begin
                    n_left  = 1'b0;
                    o_event = rebd_pkg::EV_LEFT;
                end
            end
            default: begin
                o_event = rebd_pkg::EV_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quad        <= rebd_pkg::Q_START;
            r_right       <= 1'b0;
            r_left        <= 1'b0;
            r_short       <= 1'b0;
            r_armed       <= 1'b0;
            r_was_pressed <= 1'b0;
            r_elapsed     <= '0;
        end else if (i_en) begin
            r_quad        <= n_quad;
            r_right       <= n_right;
            r_left        <= n_left;
            r_short       <= n_short;
            r_armed       <= n_armed;
            r_was_pressed <= n_was_pressed;
            r_elapsed     <= n_elapsed;
        end
    end

endmodule

`default_nettype wire

// File: sv/rotary_encoder_button_decoder.sv
// ----------------------------------------------------------------------------
// rotary_encoder_button_decoder
// Rotary encoder and push-button event decoder with valid/stall channels.
// ----------------------------------------------------------------------------
// Takes one word per clock cycle while o_in_stall is low, and returns exactly
// one event word per input word: the accepting edge loads the input register,
// and once the result register is free, the whole state update (quadrature
// table, flags, press timer, read priority) runs in a single pass into the
// result register. The input side keeps accepting while a result waits, as
// long as the result register is free or being drained in the same cycle.
// Configuration writes take effect on the next word and should be made only
// while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module rotary_encoder_button_decoder #(
    parameter int TIMER_WIDTH = rebd_pkg::TIMER_WIDTH
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic [rebd_pkg::CFG_IDX_WIDTH-1:0]   i_cfg_idx,
    input  wire logic [rebd_pkg::CFG_WIDTH-1:0]       i_cfg_data,
    input  wire logic                                 i_in_valid,
    output      logic                                 o_in_stall,
    input  wire logic [1:0]                           i_op,
    input  wire logic                                 i_pin_a,
    input  wire logic                                 i_pin_b,
    input  wire logic                                 i_button_level,
    output      logic                                 o_out_valid,
    input  wire logic                                 i_out_stall,
    output      logic [2:0]                           o_event_res
);

    logic [rebd_pkg::CFG_WIDTH-1:0] r_debounce;
    logic [rebd_pkg::CFG_WIDTH-1:0] r_long_press;

    rebd_pkg::t_in_word r_word;
    logic               r_word_valid;
    rebd_pkg::t_event   r_event;
    logic               r_out_valid;

    rebd_pkg::t_event   w_event;
    logic               w_out_free;
    logic               w_advance;

    assign w_out_free = ~r_out_valid | ~i_out_stall;
    assign w_advance  = r_word_valid & w_out_free;
    assign o_in_stall = r_word_valid & ~w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce   <= rebd_pkg::DEBOUNCE_RESET;
            r_long_press <= rebd_pkg::LONG_PRESS_RESET;
        end else if (i_cfg_we) begin
            case (rebd_pkg::t_reg_idx'(i_cfg_idx))
                rebd_pkg::REG_DEBOUNCE:   r_debounce   <= i_cfg_data;
                rebd_pkg::REG_LONG_PRESS: r_long_press <= i_cfg_data;
                default: begin
                    r_debounce <= r_debounce;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_word_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_word.op           <= rebd_pkg::t_op'(i_op);
            r_word.pin_a        <= i_pin_a;
            r_word.pin_b        <= i_pin_b;
            r_word.button_level <= i_button_level;
        end
    end

    rebd_core #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_advance),
        .i_word       (r_word),
        .i_debounce   (r_debounce),
        .i_long_press (r_long_press),
        .o_event      (w_event)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_word_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_event <= w_event;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_event_res = r_event;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the rotary encoder and button event decoder.
// ----------------------------------------------------------------------------
// Words come off a queue through a clocked driver. An in-bench decoder model
// computes the event each accepted word must produce. A clocked monitor pops
// that expectation for every returned word. Phases after the first set their
// own decoder timing, most also their sender-idle and receiver-stall rates.
// The run covers directed turns, short, long and bounced presses, random press
// and rotation sequences with noise, and both timing registers at full scale.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    rebd_pkg::t_reg_idx             cfg_idx = rebd_pkg::REG_DEBOUNCE;
    logic [rebd_pkg::CFG_WIDTH-1:0] cfg_data = '0;
    logic                           in_valid = 1'b0;
    rebd_pkg::t_in_word             in_word = '0;
    logic                           out_stall = 1'b0;
    logic                           o_in_stall;
    logic                           o_out_valid;
    logic [2:0]                     o_event_res;

    rebd_pkg::t_in_word pending_words[$];
    rebd_pkg::t_event   expected_events[$];
    int                 send_idle_pct = 0;
    int                 stall_pct = 0;
    int                 mismatch_count = 0;

    // decoder model state
    rebd_pkg::t_quad                  quad_pos;
    logic                             turned_right;
    logic                             turned_left;
    logic                             short_pending;
    logic                             press_armed;
    logic                             button_down;
    logic [rebd_pkg::TIMER_WIDTH-1:0] press_timer;
    logic [rebd_pkg::CFG_WIDTH-1:0]   cfg_debounce;
    logic [rebd_pkg::CFG_WIDTH-1:0]   cfg_long_press;

    rotary_encoder_button_decoder dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_idx      (cfg_idx),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_stall     (o_in_stall),
        .i_op           (in_word.op),
        .i_pin_a        (in_word.pin_a),
        .i_pin_b        (in_word.pin_b),
        .i_button_level (in_word.button_level),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (out_stall),
        .o_event_res    (o_event_res)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic rebd_pkg::t_event predict_event(rebd_pkg::t_in_word w);
        rebd_pkg::t_event ev;
        logic [1:0]       pins;
        ev = rebd_pkg::EV_NONE;
        pins = {w.pin_b, w.pin_a};
        case (w.op)
            rebd_pkg::OP_TICK: begin
                if (press_timer != '1)
                    press_timer = press_timer + 1'b1;
            end
            rebd_pkg::OP_QUAD: begin
                case (quad_pos)
                    rebd_pkg::Q_CWF: begin
                        case (pins)
                            2'b00: quad_pos = rebd_pkg::Q_CWN;
                            2'b10: quad_pos = rebd_pkg::Q_CWF;
                            2'b11: begin
                                quad_pos = rebd_pkg::Q_START;
                                turned_right = 1'b1;
                            end
                            default: quad_pos = rebd_pkg::Q_START;
                        endcase
                    end
                    rebd_pkg::Q_CWB: begin
                        case (pins)
                            2'b00: quad_pos = rebd_pkg::Q_CWN;
                            2'b01: quad_pos = rebd_pkg::Q_CWB;
                            default: quad_pos = rebd_pkg::Q_START;
                        endcase
                    end
                    rebd_pkg::Q_CWN: begin
                        case (pins)
                            2'b00: quad_pos = rebd_pkg::Q_CWN;
                            2'b01: quad_pos = rebd_pkg::Q_CWB;
                            2'b10: quad_pos = rebd_pkg::Q_CWF;
                            default: quad_pos = rebd_pkg::Q_START;
                        endcase
                    end
                    rebd_pkg::Q_CCWB: begin
                        case (pins)
                            2'b00: quad_pos = rebd_pkg::Q_CCWN;
                            2'b10: quad_pos = rebd_pkg::Q_CCWB;
                            default: quad_pos = rebd_pkg::Q_START;
                        endcase
                    end
                    rebd_pkg::Q_CCWF: begin
                        case (pins)
                            2'b00: quad_pos = rebd_pkg::Q_CCWN;
                            2'b01: quad_pos = rebd_pkg::Q_CCWF;
                            2'b11: begin
                                quad_pos = rebd_pkg::Q_START;
                                turned_left = 1'b1;
                            end
                            default: quad_pos = rebd_pkg::Q_START;
                        endcase
                    end
                    rebd_pkg::Q_CCWN: begin
                        case (pins)
                            2'b00: quad_pos = rebd_pkg::Q_CCWN;
                            2'b01: quad_pos = rebd_pkg::Q_CCWF;
                            2'b10: quad_pos = rebd_pkg::Q_CCWB;
                            default: quad_pos = rebd_pkg::Q_START;
                        endcase
                    end
                    default: begin
                        case (pins)
                            2'b01: quad_pos = rebd_pkg::Q_CWB;
                            2'b10: quad_pos = rebd_pkg::Q_CCWB;
                            default: quad_pos = rebd_pkg::Q_START;
                        endcase
                    end
                endcase
                press_timer = '0;
            end
            rebd_pkg::OP_BUTTON: begin
                if (press_timer >= cfg_debounce) begin
                    if (!button_down) begin
                        press_armed = 1'b1;
                    end else if (press_timer <= cfg_long_press
                                 && press_armed) begin
                        short_pending = 1'b1;
                        press_armed = 1'b0;
                    end
                    button_down = !w.button_level;
                    press_timer = '0;
                end
            end
            default: begin
                if (short_pending) begin
                    short_pending = 1'b0;
                    ev = rebd_pkg::EV_SHORT;
                end else if (press_armed && press_timer >= cfg_long_press) begin
                    press_armed = 1'b0;
                    ev = rebd_pkg::EV_LONG;
                end else if (turned_right) begin
                    turned_right = 1'b0;
                    ev = rebd_pkg::EV_RIGHT;
                end else if (turned_left) begin
                    turned_left = 1'b0;
                    ev = rebd_pkg::EV_LEFT;
                end
            end
        endcase
        return ev;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 20)
            $display("%0t mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // driver
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && !o_in_stall)
                expected_events.push_back(predict_event(in_word));
            if (!in_valid || !o_in_stall) begin
                if (pending_words.size() != 0
                    && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_word  <= pending_words.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        if (rst_n && o_out_valid && !out_stall) begin
            if (expected_events.size() == 0) begin
                report_mismatch($sformatf("unexpected word, event_res %0d", o_event_res));
            end else if (o_event_res !== expected_events[0]) begin
                report_mismatch($sformatf("event_res %0d, wanted %0d",
                                          o_event_res, expected_events[0]));
                void'(expected_events.pop_front());
            end else begin
                void'(expected_events.pop_front());
            end
        end
        out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
    end

    task automatic push_word(rebd_pkg::t_op op, logic [1:0] pins, logic level);
        rebd_pkg::t_in_word w;
        w.op = op;
        w.pin_b = pins[1];
        w.pin_a = pins[0];
        w.button_level = level;
        pending_words.push_back(w);
    endtask

    task automatic push_ticks(int n);
        repeat (n) push_word(rebd_pkg::OP_TICK, 2'($urandom), 1'($urandom));
    endtask

    task automatic push_read();
        push_word(rebd_pkg::OP_READ, 2'($urandom), 1'($urandom));
    endtask

    task automatic push_button(logic level);
        push_word(rebd_pkg::OP_BUTTON, 2'($urandom), level);
    endtask

    // one detent; glitch_pct inserts random pin pairs along the way
    task automatic push_turn(bit clockwise, int glitch_pct);
        logic [1:0] cw_seq[4];
        logic [1:0] ccw_seq[4];
        cw_seq = '{2'b01, 2'b00, 2'b10, 2'b11};
        ccw_seq = '{2'b10, 2'b00, 2'b01, 2'b11};
        for (int i = 0; i < 4; i++) begin
            if ($urandom_range(0, 99) < glitch_pct)
                push_word(rebd_pkg::OP_QUAD, 2'($urandom), 1'($urandom));
            push_word(rebd_pkg::OP_QUAD, clockwise ? cw_seq[i] : ccw_seq[i],
                      1'($urandom));
        end
    endtask

    function automatic int near_count(int threshold);
        int n;
        n = threshold + int'($urandom_range(0, 4)) - 2;
        if (n < 0)
            n = 0;
        if (n > 40)
            n = int'($urandom_range(30, 40));
        return n;
    endfunction

    task automatic push_random_sequence();
        int pick;
        pick = int'($urandom_range(0, 99));
        if (pick < 30) begin
            push_turn(1'($urandom), 15);
            if ($urandom_range(0, 1))
                push_read();
        end else if (pick < 60) begin
            push_ticks(near_count(int'(cfg_debounce)));
            push_button($urandom_range(0, 4) != 0 ? 1'b0 : 1'b1);
            if ($urandom_range(0, 3) == 0)
                push_read();
            push_ticks(near_count(int'(cfg_long_press)));
            if ($urandom_range(0, 1))
                push_read();
            push_ticks(near_count(int'(cfg_debounce)) / 2);
            push_button(1'($urandom_range(0, 4) != 0));
            push_read();
            push_read();
        end else if (pick < 75) begin
            repeat ($urandom_range(1, 3)) push_read();
        end else if (pick < 85) begin
            push_ticks($urandom_range(1, 12));
        end else begin
            repeat ($urandom_range(1, 4))
                push_word(rebd_pkg::t_op'($urandom_range(0, 3)), 2'($urandom),
                          1'($urandom));
        end
    endtask

    task automatic fill_random(int n);
        int target;
        target = pending_words.size() + n;
        while (pending_words.size() < target)
            push_random_sequence();
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (pending_words.size() != 0 || in_valid || expected_events.size() != 0);
    endtask

    task automatic write_regs(logic [rebd_pkg::CFG_WIDTH-1:0] debounce,
                              logic [rebd_pkg::CFG_WIDTH-1:0] hold_limit);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= rebd_pkg::REG_DEBOUNCE;
        cfg_data <= debounce;
        @(posedge clk);
        cfg_idx  <= rebd_pkg::REG_LONG_PRESS;
        cfg_data <= hold_limit;
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_debounce = debounce;
        cfg_long_press = hold_limit;
        @(negedge clk);
    endtask

    task automatic set_idling(int idle_pct, int stall);
        send_idle_pct = idle_pct;
        stall_pct = stall;
    endtask

    initial begin
        quad_pos = rebd_pkg::Q_START;
        turned_right = 1'b0;
        turned_left = 1'b0;
        short_pending = 1'b0;
        press_armed = 1'b0;
        button_down = 1'b0;
        press_timer = '0;
        cfg_debounce = rebd_pkg::DEBOUNCE_RESET;
        cfg_long_press = rebd_pkg::LONG_PRESS_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset timing: turns both ways, press inside debounce is dropped
        push_read();
        push_turn(1'b1, 0);
        push_read();
        push_turn(1'b0, 0);
        push_read();
        push_read();
        push_button(1'b0);
        push_read();
        wait_drained();

        write_regs(16'd2, 16'd6);
        push_ticks(2);
        push_button(1'b0);
        push_ticks(3);
        push_button(1'b1);
        push_turn(1'b1, 0);
        push_read();
        push_read();
        // released level seen again still arms a press
        push_ticks(2);
        push_button(1'b1);
        push_ticks(6);
        push_read();
        push_read();
        fill_random(170);
        wait_drained();

        write_regs(16'd0, 16'd0);
        set_idling(65, 0);
        fill_random(170);
        wait_drained();

        write_regs(16'd3, 16'd12);
        set_idling(0, 65);
        fill_random(170);
        wait_drained();

        write_regs(16'd1, 16'd5);
        set_idling(6, 6);
        fill_random(170);
        wait_drained();

        // full-scale timing: button changes stay inside debounce
        write_regs(16'hFFFF, 16'hFFFF);
        set_idling(0, 0);
        push_turn(1'b0, 0);
        push_ticks(30);
        push_button(1'b0);
        push_ticks(30);
        push_button(1'b1);
        push_read();
        push_read();
        push_read();
        wait_drained();

        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
